// ----- rtl/rfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Rangefinder frame averager package
// Field widths, frame tags, register indexes and reset values shared by the
// averager and its channel interfaces.
// ----------------------------------------------------------------------------
package rfa_pkg;

    localparam int BYTE_W  = 8;
    localparam int LOW_W   = 6;
    localparam int RAW_W   = 2 * LOW_W;
    localparam int CNT_W   = 10;
    localparam int SCALE_W = 8;
    localparam int SUM_W   = 22;
    localparam int DIST_W  = 20;
    localparam int PROD_W  = SUM_W + SCALE_W;
    localparam int CFG_W   = CNT_W;

    localparam int MAX_AVERAGE_COUNT = 1023;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [CNT_W-1:0]   t_count;
    typedef logic [SCALE_W-1:0] t_scale;
    typedef logic [DIST_W-1:0]  t_dist;
    typedef logic [CFG_W-1:0]   t_cfg_data;

    // Top two bits of a received byte.
    localparam logic [1:0] HEAD_TAG = 2'b10;
    localparam logic [1:0] TAIL_TAG = 2'b00;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_AVERAGE_COUNT = 1'b0,
        REG_SCALE         = 1'b1
    } t_cfg_index;

    localparam t_count RST_AVERAGE_COUNT = t_count'(100);
    localparam t_scale RST_SCALE         = t_scale'(10);

endpackage

// ----- rtl/rfa_in_if.sv -----
// ----------------------------------------------------------------------------
// Rangefinder byte channel
// Valid/ready channel that carries one received byte per transfer.
// ----------------------------------------------------------------------------
interface rfa_in_if;
    logic           valid;
    logic           ready;
    rfa_pkg::t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/rfa_out_if.sv -----
// ----------------------------------------------------------------------------
// Rangefinder result channel
// Valid/ready channel that carries one averaged distance per transfer.
// ----------------------------------------------------------------------------
interface rfa_out_if;
    logic            valid;
    logic            ready;
    rfa_pkg::t_dist  distance_cm;
    rfa_pkg::t_count samples_averaged;

    modport source (output valid, output distance_cm, output samples_averaged, input ready);
    modport sink   (input valid, input distance_cm, input samples_averaged, output ready);
endinterface

// ----- rtl/rangefinder_frame_averager.sv -----
// A byte that does not close an averaging window is absorbed while the input stays ready.
// A byte that triggers an average leads to a valid result through these steps in order:
// a shift-add multiply, a restoring divide, and a load of the output register.
// Input takes one byte per cycle while idle; it is held off during those steps, and longer
// while the previous result has not been taken. Reset (synchronous, active low) sets
// average_count 100 and scale 10 and clears the frame hunter, sum, count and output valid.
// ----------------------------------------------------------------------------
// Rangefinder frame averager
// Reassembles two-byte distance frames, sums them, and emits the scaled
// average over each window using a serial multiplier and divider.
// ----------------------------------------------------------------------------
module rangefinder_frame_averager (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  rfa_pkg::t_cfg_data     i_cfg_wdata,
    rfa_in_if.sink                 i_rx,
    rfa_out_if.source              o_res
);
    import rfa_pkg::*;

    localparam int MUL_STEPS = SCALE_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} t_state;

    t_state              r_state;
    t_count              r_avg_count;
    t_scale              r_scale;
    logic                r_head_held;
    logic [LOW_W-1:0]    r_head_low;
    logic [SUM_W-1:0]    r_sum;
    t_count              r_sample_count;

    logic [SUM_W-1:0]    r_mcand;
    t_scale              r_mplier;
    logic [PROD_W-1:0]   r_acc;
    logic [CNT_W-1:0]    r_rem;
    t_count              r_divisor;
    logic [STEP_W-1:0]   r_step;

    logic                r_out_valid;
    t_dist               r_dist;
    t_count              r_out_cnt;

    logic                in_xfer;
    logic [1:0]          tag;
    logic [RAW_W-1:0]    raw;
    t_count              eff_count;
    logic [PROD_W-1:0]   mul_next;
    logic [CNT_W:0]      trial;
    logic                trial_ge;
    logic [CNT_W:0]      trial_diff;
    logic                out_free;

    assign i_rx.ready = (r_state == S_IDLE);
    assign in_xfer    = i_rx.valid && i_rx.ready;
    assign tag        = i_rx.rx_byte[BYTE_W-1 -: 2];
    assign raw        = {r_head_low, i_rx.rx_byte[LOW_W-1:0]};
    assign out_free   = !r_out_valid || o_res.ready;

    // A window length of zero counts as one; the upper clamp guards larger limits.
    always_comb begin
        eff_count = (r_avg_count == '0) ? t_count'(1) : r_avg_count;
        if (32'(eff_count) > 32'(MAX_AVERAGE_COUNT)) begin
            eff_count = t_count'(MAX_AVERAGE_COUNT);
        end
    end

    // One multiplier bit per cycle, most significant first.
    assign mul_next = {r_acc[PROD_W-2:0], 1'b0}
                    + (r_mplier[SCALE_W-1] ? PROD_W'(r_mcand) : '0);

    // One quotient bit per cycle; the quotient shifts into the dividend register.
    assign trial      = {r_rem, r_acc[PROD_W-1]};
    assign trial_ge   = trial >= {1'b0, r_divisor};
    assign trial_diff = trial - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_avg_count    <= RST_AVERAGE_COUNT;
            r_scale        <= RST_SCALE;
            r_head_held    <= 1'b0;
            r_sum          <= '0;
            r_sample_count <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    REG_AVERAGE_COUNT: r_avg_count <= i_cfg_wdata[CNT_W-1:0];
                    REG_SCALE:         r_scale     <= i_cfg_wdata[SCALE_W-1:0];
                    default:           r_scale     <= r_scale;
                endcase
            end

            // A new result may replace the one taken in this same cycle.
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (!r_head_held) begin
                            if (tag == HEAD_TAG) begin
                                r_head_held <= 1'b1;
                                r_head_low  <= i_rx.rx_byte[LOW_W-1:0];
                            end
                        end else if (tag == TAIL_TAG) begin
                            r_head_held <= 1'b0;
                            if (r_sample_count < eff_count) begin
                                r_sum          <= r_sum + SUM_W'(raw);
                                r_sample_count <= r_sample_count + t_count'(1);
                            end else begin
                                // The closing frame itself is not summed.
                                r_mcand        <= r_sum;
                                r_mplier       <= r_scale;
                                r_divisor      <= r_sample_count;
                                r_acc          <= '0;
                                r_rem          <= '0;
                                r_step         <= '0;
                                r_sum          <= '0;
                                r_sample_count <= '0;
                                r_state        <= S_MUL;
                            end
                        end
                    end
                end
                S_MUL: begin
                    r_acc    <= mul_next;
                    r_mplier <= {r_mplier[SCALE_W-2:0], 1'b0};
                    if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_DIV: begin
                    r_rem <= trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
                    r_acc <= {r_acc[PROD_W-2:0], trial_ge};
                    if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_dist      <= (r_divisor == '0) ? '0 : r_acc[DIST_W-1:0];
                        r_out_cnt   <= r_divisor;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.distance_cm      = r_dist;
    assign o_res.samples_averaged = r_out_cnt;

endmodule
